// ----- rtl/csc_pkg.sv -----
// csc_pkg: sizes, operation codes and shared types for the coordinate set CAM.
// Used by the slot store, the top level and the checker. No dependencies.
package csc_pkg;

  // Set geometry
  localparam int SLOTS      = 16;
  localparam int COORD_BITS = 8;

  // Port field widths
  localparam int POS_W   = 8;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 5;

  // Derived sizes
  localparam int PAIR_W    = 2 * COORD_BITS;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int COUNT_MAX = (SLOTS < 31) ? SLOTS : 31;

  typedef logic [PAIR_W-1:0] pair_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Operation handed to the slot store
  typedef struct packed {
    logic  fire;
    mode_t mode;
    pair_t key;
  } csc_req_t;

  // Result returned by the slot store
  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } csc_rsp_t;

endpackage

// ----- rtl/csc_if.sv -----
// csc_if: valid/ready channel interfaces for the coordinate set CAM.
// csc_in_if carries operations, csc_out_if carries results. No dependencies.
interface csc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pos_x;
  logic [7:0] pos_y;

  modport source (output valid, mode, pos_x, pos_y, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, output ready);
endinterface

interface csc_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [4:0] count;

  modport source (output valid, ok, count, input ready);
  modport sink   (input valid, ok, count, output ready);
endinterface

// ----- rtl/csc_slots.sv -----
// csc_slots: slot store with per-slot valid bits, parallel match and priority pick.
// Depends on csc_pkg.
module csc_slots (
  input  logic              clk,
  input  logic              rst_n,
  input  csc_pkg::csc_req_t req,
  output csc_pkg::csc_rsp_t rsp
);
  import csc_pkg::*;

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  pair_t            coord_r [SLOTS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] free;
  logic [SLOTS-1:0] free_sel;
  logic [SLOTS-1:0] hit_sel;
  logic             any_free;
  logic             any_hit;
  logic             ok_nxt;

  // Compare every valid slot against the key
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = valid_r[i] && (coord_r[i] == req.key);
    end
  end

  // Lowest free slot and lowest matching slot, one-hot
  assign free     = ~valid_r;
  assign free_sel = free & (~free + SLOTS'(1));
  assign hit_sel  = hit & (~hit + SLOTS'(1));
  assign any_free = |free;
  assign any_hit  = |hit;

  // Next valid mask, count and ok flag
  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = 1'b0;
    case (req.mode)
      MODE_INSERT: begin
        if (any_free) begin
          valid_nxt = valid_r | free_sel;
          cnt_nxt   = cnt_r + CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (any_hit) begin
          valid_nxt = valid_r & ~hit_sel;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      MODE_LOOKUP: begin
        ok_nxt = any_hit;
      end
      MODE_CLEAR: begin
        valid_nxt = '0;
        cnt_nxt   = '0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // Result, count saturated to the port width
  always_comb begin
    rsp.ok = ok_nxt;
    if (int'(cnt_nxt) > COUNT_MAX) begin
      rsp.count = COUNT_W'(COUNT_MAX);
    end else begin
      rsp.count = COUNT_W'(cnt_nxt);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (req.fire) begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Coordinate storage, written only into the picked free slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (req.fire && (req.mode == MODE_INSERT) && free_sel[i]) begin
        coord_r[i] <= req.key;
      end
    end
  end

endmodule

// ----- rtl/coordinate_set_cam.sv -----
// Coordinate set CAM: holds up to SLOTS (x, y) pairs and runs insert, remove, lookup and
// clear operations, one transaction per clock cycle sustained while results are taken. Each
// transaction lands in an input register, all slots are compared in parallel and a
// priority pick chooses the slot in one combinational stage, and the result is registered
// in the result register. Results come back in order, one per operation, each with the
// valid-slot count after that operation. The input stays ready while a result waits, as
// long as the input register can move on. No clearing pass is needed after reset.
// Depends on csc_pkg, csc_if and csc_slots.
module coordinate_set_cam (
  input  logic             clk,
  input  logic             rst_n,
  csc_in_if.sink           in_if,
  csc_out_if.source        out_if
);
  import csc_pkg::*;

  // Input register
  logic             s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [POS_W-1:0] s1_x_r;
  logic [POS_W-1:0] s1_y_r;
  logic             s1_adv;
  logic             in_fire;

  // Result register
  logic               out_valid_r;
  logic               out_ok_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [COORD_BITS-1:0] key_x;
  logic [COORD_BITS-1:0] key_y;
  csc_req_t              req;
  csc_rsp_t              rsp;

  // Handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_if.mode;
      s1_x_r    <= in_if.pos_x;
      s1_y_r    <= in_if.pos_y;
    end
  end

  // Key: low COORD_BITS of each coordinate, x in the low half
  assign key_x = COORD_BITS'({{COORD_BITS{1'b0}}, s1_x_r});
  assign key_y = COORD_BITS'({{COORD_BITS{1'b0}}, s1_y_r});

  assign req.fire = s1_adv;
  assign req.mode = mode_t'(s1_mode_r);
  assign req.key  = {key_y, key_x};

  csc_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ok_r    <= rsp.ok;
      out_count_r <= rsp.count;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.ok    = out_ok_r;
  assign out_if.count = out_count_r;

endmodule

// ----- rtl/csc_checker.sv -----
// csc_checker: port-level assertions for coordinate_set_cam, bound to the top level.
// Depends on csc_pkg.
module csc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_ok,
  input logic [4:0] out_count
);
  import csc_pkg::*;

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_count))
    else $error("result changed while stalled");

  // Count never exceeds the slot capacity
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_count) <= COUNT_MAX))
    else $error("count above capacity");

  // A successful insert or a found lookup leaves at least one valid slot
  a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_count != 5'd0)
    else $error("ok reported with empty set");

  // Nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind coordinate_set_cam csc_checker u_csc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_ok    (out_if.ok),
  .out_count (out_if.count)
);

// ----- test/tb.sv -----
// tb: self-checking testbench for coordinate_set_cam, with a clocked driver, monitor and
// running model of the slot set. Depends on csc_pkg, csc_if and the coordinate_set_cam RTL.
`timescale 1ns / 100ps

module tb;
  import csc_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off to back up the block
  localparam int IDLE_LIMIT  = 3000;  // cycles without any transaction before giving up
  localparam int DRAIN_WAIT  = 10;    // drain margin for any stray result
  localparam int POOL_N      = 6;

  typedef struct {
    mode_t              mode;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
  } cam_op_t;

  logic clk;
  logic rst_n;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  coordinate_set_cam u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Pending operations, expected results, and the model of the slot set
  cam_op_t    op_queue [$];
  csc_rsp_t   rsp_expected [$];
  logic [SLOTS-1:0] set_valid;
  pair_t      set_pairs [SLOTS];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_granted;
  int hold_left;
  int idle_cycles;
  int mismatch_count;
  int ops_queued;

  logic [POS_W-1:0] pool_x [POOL_N];
  logic [POS_W-1:0] pool_y [POOL_N];

  // Apply one operation to the model set and return the result it produces
  function automatic csc_rsp_t apply_op(cam_op_t op);
    pair_t    key;
    csc_rsp_t rsp;
    int       n;
    bit       done;
    key    = {op.y[COORD_BITS-1:0], op.x[COORD_BITS-1:0]};
    rsp.ok = 1'b0;
    done   = 1'b0;
    case (op.mode)
      MODE_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !set_valid[i]) begin
            set_pairs[i] = key;
            set_valid[i] = 1'b1;
            rsp.ok       = 1'b1;
            done         = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && set_valid[i] && set_pairs[i] == key) begin
            set_valid[i] = 1'b0;
            done         = 1'b1;
          end
        end
      end
      MODE_LOOKUP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (set_valid[i] && set_pairs[i] == key) rsp.ok = 1'b1;
        end
      end
      default: set_valid = '0;
    endcase
    n = $countones(set_valid);
    if (n > 31) n = 31;
    rsp.count = n[COUNT_W-1:0];
    return rsp;
  endfunction

  task automatic push_op(mode_t mode, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    cam_op_t op;
    op.mode = mode;
    op.x    = x;
    op.y    = y;
    op_queue.push_back(op);
    ops_queued++;
  endtask

  // Mostly pairs from a small pool so inserts, removes and lookups hit each other
  task automatic pick_pair(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y);
    int idx;
    if ($urandom_range(99) < 80) begin
      idx = $urandom_range(POOL_N - 1);
      x   = pool_x[idx];
      y   = pool_y[idx];
    end else begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end
  endtask

  // New pool: includes neighbors one bit away from the first pair
  task automatic new_pool();
    for (int i = 0; i < POOL_N; i++) begin
      pool_x[i] = POS_W'($urandom);
      pool_y[i] = POS_W'($urandom);
    end
    pool_x[1] = pool_x[0] ^ (8'h01 << $urandom_range(POS_W - 1));
    pool_y[1] = pool_y[0];
    pool_x[2] = pool_x[0];
    pool_y[2] = pool_y[0] ^ (8'h01 << $urandom_range(POS_W - 1));
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || in_ch.valid || rsp_expected.size() != 0)
      @(negedge clk);
  endtask

  // One phase of random sequences under the given idling
  task automatic run_phase(int send_pct, int recv_pct, int n_ops, bit hold_off);
    logic [POS_W-1:0] x, y;
    int start, kind, r, n;
    start          = ops_queued;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    new_pool();
    if (hold_off) hold_request++;
    while (ops_queued - start < n_ops) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        // fill run: 4 to 20 inserts, sometimes after a clear, so the set can fill up
        if ($urandom_range(3) == 0) push_op(MODE_CLEAR, POS_W'($urandom), POS_W'($urandom));
        n = $urandom_range(4, 20);
        repeat (n) begin
          pick_pair(x, y);
          push_op(MODE_INSERT, x, y);
        end
      end else if (kind < 80) begin
        repeat (10) begin
          pick_pair(x, y);
          r = $urandom_range(99);
          if (r < 40)      push_op(MODE_INSERT, x, y);
          else if (r < 65) push_op(MODE_REMOVE, x, y);
          else if (r < 95) push_op(MODE_LOOKUP, x, y);
          else             push_op(MODE_CLEAR, x, y);
        end
      end else begin
        // noise: anything at all
        repeat (4) push_op(mode_t'($urandom_range(3)), POS_W'($urandom), POS_W'($urandom));
      end
    end
    wait_drained();
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset and known input values from time zero
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_INSERT;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offers the next operation and feeds the model on each accepted transaction
  always @(posedge clk) begin
    cam_op_t op;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      set_valid = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        op.mode = mode_t'(in_ch.mode);
        op.x    = in_ch.pos_x;
        op.y    = in_ch.pos_y;
        rsp_expected.push_back(apply_op(op));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = op_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode  <= op.mode;
          in_ch.pos_x <= op.x;
          in_ch.pos_y <= op.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and drives ready, with a long hold on request
  always @(posedge clk) begin
    csc_rsp_t exp_rsp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_granted <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected result ok %0b count %0d", $time, out_ch.ok, out_ch.count);
          mismatch_count++;
        end else begin
          exp_rsp = rsp_expected.pop_front();
          if (out_ch.ok !== exp_rsp.ok) begin
            $display("%0t: ok mismatch, expected %0b actual %0b", $time, exp_rsp.ok,
                     out_ch.ok);
            mismatch_count++;
          end
          if (out_ch.count !== exp_rsp.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d", $time, exp_rsp.count,
                     out_ch.count);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_granted != hold_request) begin
        hold_granted <= hold_request;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("coordinate_set_cam verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    mismatch_count = 0;
    ops_queued     = 0;
    hold_request   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (!rst_n) @(negedge clk);
    @(negedge clk);

    // directed: extremes, duplicates, absent removes, clear
    push_op(MODE_INSERT, 8'h00, 8'h00);
    push_op(MODE_INSERT, 8'hFF, 8'hFF);
    push_op(MODE_INSERT, 8'h80, 8'h01);
    push_op(MODE_LOOKUP, 8'h00, 8'h00);
    push_op(MODE_LOOKUP, 8'hFF, 8'hFF);
    push_op(MODE_LOOKUP, 8'hFF, 8'hFE);
    push_op(MODE_LOOKUP, 8'h7F, 8'hFF);
    push_op(MODE_INSERT, 8'hFF, 8'hFF);
    push_op(MODE_REMOVE, 8'hFF, 8'hFF);
    push_op(MODE_LOOKUP, 8'hFF, 8'hFF);
    push_op(MODE_REMOVE, 8'hFF, 8'hFF);
    push_op(MODE_LOOKUP, 8'hFF, 8'hFF);
    push_op(MODE_REMOVE, 8'hFF, 8'hFF);
    push_op(MODE_CLEAR,  8'hFF, 8'hFF);
    push_op(MODE_LOOKUP, 8'h00, 8'h00);
    push_op(MODE_REMOVE, 8'h00, 8'h00);
    push_op(MODE_CLEAR,  8'h00, 8'h00);
    wait_drained();

    run_phase(0, 0, 180, 1'b0);
    run_phase(59, 0, 180, 1'b0);
    run_phase(0, 59, 180, 1'b0);
    run_phase(19, 19, 180, 1'b0);
    run_phase(0, 0, 180, 1'b1);

    // let any stray result show up with ready held high
    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(negedge clk);
    if (rsp_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, rsp_expected.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("coordinate_set_cam verification clean");
    end else begin
      $display("coordinate_set_cam verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/csc_pkg.sv
rtl/csc_if.sv
rtl/csc_slots.sv
rtl/coordinate_set_cam.sv
rtl/csc_checker.sv
test/tb.sv
